FILE: hw/rtl/hsort_pkg.sv
// hsort_pkg: shared types and constants for the heap sorter
// depends on nothing; used by hsort_loader, hsort_engine and heap_sorter
`timescale 1ns / 1ps

package hsort_pkg;

	localparam int unsigned DATA_W = 32;

	// batch descriptor handed from the loader to the sort engine
	typedef struct packed {
		logic [6:0] count;
		logic       trunc;
	} batch_t;

endpackage

FILE: hw/rtl/hsort_loader.sv
// hsort_loader: front end, takes input beats and classifies them as store or drop
// depends on hsort_pkg; feeds the batch queue in heap_sorter
`timescale 1ns / 1ps

module hsort_loader #(
	parameter int unsigned MAX_ITEMS = 64,
	parameter int unsigned AW        = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [hsort_pkg::DATA_W-1:0] in_value,
	input  logic                             in_last,
	input  logic                             mem_free,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic [hsort_pkg::DATA_W-1:0]     wr_data,
	output logic                             batch_valid,
	input  logic                             batch_ready,
	output hsort_pkg::batch_t                batch
);

	logic [6:0] count_q;
	logic       ovf_q;
	logic       fire;
	logic       room;

	assign in_ready = mem_free && batch_ready;
	assign fire     = in_valid && in_ready;
	assign room     = count_q < 7'(MAX_ITEMS);

	// store write for a beat that fits
	assign wr_en   = fire && room;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = in_value;

	// batch hand-off when the last beat arrives
	assign batch_valid = fire && in_last;
	assign batch.count = room ? count_q + 7'd1 : count_q;
	assign batch.trunc = ovf_q || !room;

	// fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			if (in_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (room) begin
				count_q <= count_q + 7'd1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/hsort_engine.sv
// hsort_engine: back end, heapsort over the element store and result emission
// depends on hsort_pkg; owns the element memory (one write, one read port)
`timescale 1ns / 1ps

module hsort_engine #(
	parameter int unsigned AW = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ld_en,
	input  logic [AW-1:0]                ld_addr,
	input  logic [hsort_pkg::DATA_W-1:0] ld_data,
	output logic                         mem_free,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  hsort_pkg::batch_t            job,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [hsort_pkg::DATA_W-1:0] out_value,
	output logic                         out_last,
	output logic                         out_trunc
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BUILD = 4'd1;
	localparam logic [3:0] S_RD_R  = 4'd2;
	localparam logic [3:0] S_RD_L  = 4'd3;
	localparam logic [3:0] S_RD_RT = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_SWAP  = 4'd6;
	localparam logic [3:0] S_EXT   = 4'd7;
	localparam logic [3:0] S_EXT2  = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;
	localparam logic [3:0] S_EMIT2 = 4'd10;
	localparam logic [3:0] S_SWAP2 = 4'd11;
	localparam logic [3:0] S_EXT3  = 4'd12;

	logic [hsort_pkg::DATA_W-1:0] mem [2**AW];
	logic [hsort_pkg::DATA_W-1:0] rd_data_q;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [hsort_pkg::DATA_W-1:0] wr_data;

	logic [3:0] state_q;
	logic [6:0] n_q;       // batch size
	logic [6:0] heap_q;    // current heap size
	logic [6:0] bld_q;     // next build root plus one
	logic [6:0] root_q;
	logic [6:0] big_q;
	logic [6:0] emit_q;
	logic       trunc_q;
	logic       build_q;
	logic signed [hsort_pkg::DATA_W-1:0] vroot_q, vbig_q;
	logic [7:0] lc, rc;

	assign lc = {root_q, 1'b0} + 8'd1;
	assign rc = {root_q, 1'b0} + 8'd2;

	assign mem_free  = (state_q == S_IDLE);
	assign job_ready = (state_q == S_IDLE);

	// element memory, registered read (read returns the old word on a same-address write)
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// read address and write port selection
	always_comb begin
		rd_addr = root_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = ld_addr;
		wr_data = ld_data;
		unique case (state_q)
			S_IDLE: begin
				wr_en = ld_en;
			end
			S_RD_L:  rd_addr = lc[AW-1:0];
			S_RD_RT: rd_addr = rc[AW-1:0];
			S_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = root_q[AW-1:0];
				wr_data = vbig_q;
			end
			S_SWAP2: begin
				wr_en   = 1'b1;
				wr_addr = big_q[AW-1:0];
				wr_data = vroot_q;
			end
			S_EXT: rd_addr = heap_q[AW-1:0];
			S_EXT2: begin
				// tail goes to the root slot while the old root is read
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = rd_data_q;
			end
			S_EXT3: begin
				// old root goes to the retired tail slot
				wr_en   = 1'b1;
				wr_addr = heap_q[AW-1:0];
				wr_data = rd_data_q;
			end
			S_EMIT, S_EMIT2: rd_addr = emit_q[AW-1:0];
			default: ;
		endcase
	end

	// heapsort sequencer (build, sift-down, extraction, emit): root, left, right read one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			n_q <= '0; heap_q <= '0; bld_q <= '0; root_q <= '0; big_q <= '0;
			emit_q <= '0; trunc_q <= 1'b0; build_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						n_q     <= job.count;
						heap_q  <= job.count;
						trunc_q <= job.trunc;
						bld_q   <= {1'b0, job.count[6:1]};
						build_q <= 1'b1;
						emit_q  <= '0;
						state_q <= (job.count < 7'd2) ?
							((job.count == 7'd0) ? S_IDLE : S_EMIT) : S_BUILD;
					end
				end
				S_BUILD: begin
					if (bld_q == 7'd0) begin
						build_q <= 1'b0;
						state_q <= S_EXT;
						heap_q  <= n_q - 7'd1;
					end else begin
						root_q  <= bld_q - 7'd1;
						bld_q   <= bld_q - 7'd1;
						state_q <= S_RD_R;
					end
				end
				S_RD_R: state_q <= S_RD_L;      // root read issued
				S_RD_L: begin                   // root data
					vroot_q <= rd_data_q;
					vbig_q  <= rd_data_q;
					big_q   <= root_q;
					state_q <= S_RD_RT;
				end
				S_RD_RT: begin                  // left child data
					if ({1'b0, heap_q} > lc && $signed(rd_data_q) > vbig_q) begin
						vbig_q <= rd_data_q;
						big_q  <= lc[6:0];
					end
					state_q <= S_CMP;
				end
				S_CMP: begin                    // right child data
					if ({1'b0, heap_q} > rc && $signed(rd_data_q) > vbig_q) begin
						vbig_q  <= rd_data_q;
						big_q   <= rc[6:0];
						state_q <= S_SWAP;
					end else if (big_q == root_q) begin
						state_q <= build_q ? S_BUILD : S_EXT;
						if (!build_q) heap_q <= heap_q - 7'd1;
					end else begin
						state_q <= S_SWAP;
					end
				end
				S_SWAP: state_q <= S_SWAP2;
				S_SWAP2: begin
					root_q  <= big_q;
					state_q <= S_RD_R;
				end
				S_EXT: begin
					// heap_q is the slot being retired; root at 0
					if (heap_q == 7'd0) begin
						state_q <= S_EMIT;
					end else begin
						root_q  <= '0;
						state_q <= S_EXT2;
					end
				end
				S_EXT2: state_q <= S_EXT3;
				S_EXT3: state_q <= S_RD_R;     // sift the new root
				S_EMIT: state_q <= S_EMIT2;
				S_EMIT2: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_value <= rd_data_q;
						out_last  <= (emit_q + 7'd1 == n_q);
						out_trunc <= trunc_q;
						if (emit_q + 7'd1 == n_q) begin
							state_q <= S_IDLE;
						end else begin
							emit_q  <= emit_q + 7'd1;
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && out_ready && !(state_q == S_EMIT2)) out_valid <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/heap_sorter.sv
// heap_sorter: top level, loader front end, batch queue, heapsort back end
// depends on hsort_pkg, hsort_loader, hsort_engine
`timescale 1ns / 1ps

// Batch sorter for signed 32-bit values. Beats are stored until one marked
// last arrives; the batch is then heap sorted in an element memory with one
// read and one write port and emitted in ascending order, last_out on the
// largest value, truncated on every result when beats beyond MAX_ITEMS were
// dropped. A beat is taken whenever in_ready is high, and the batch is handed
// to the queue with the last beat. Each sift level steps through root, left
// and right reads, compare and two swap writes; each root extraction adds a
// tail read and two writes. Input is held off while a batch is sorted or
// emitted.
module heap_sorter #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [hsort_pkg::DATA_W-1:0] value,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [hsort_pkg::DATA_W-1:0] sorted_value,
	output logic                             last_out,
	output logic                             truncated
);

	localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [hsort_pkg::DATA_W-1:0] wr_data;
	logic                         mem_free;
	logic                         b_valid, b_ready;
	hsort_pkg::batch_t            b_in;
	logic                         q_valid_q;
	hsort_pkg::batch_t            q_data_q;
	logic                         job_ready;

	hsort_loader #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_loader (
		.clk, .arst_n, .in_valid, .in_ready, .in_value(value), .in_last(last),
		.mem_free, .wr_en, .wr_addr, .wr_data,
		.batch_valid(b_valid), .batch_ready(b_ready), .batch(b_in)
	);

	// one-entry batch queue between front and back end
	assign b_ready = !q_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_q <= 1'b0;
		end else if (b_valid && b_ready) begin
			q_valid_q <= 1'b1;
		end else if (q_valid_q && job_ready) begin
			q_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (b_valid && b_ready) q_data_q <= b_in;
	end

	hsort_engine #(.AW(AW)) u_engine (
		.clk, .arst_n, .ld_en(wr_en), .ld_addr(wr_addr), .ld_data(wr_data),
		.mem_free, .job_valid(q_valid_q), .job_ready, .job(q_data_q),
		.out_valid, .out_ready, .out_value(sorted_value), .out_last(last_out),
		.out_trunc(truncated)
	);

`ifndef SYNTH
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> mem_free) else $error("load while sorting");
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid_q && !job_ready |=> q_valid_q) else $error("batch lost");
`endif

endmodule
